FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the weld cycle sequencer RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: rtl/core/wcs_pkg.sv
// Types, register indexes and speed arithmetic for the weld cycle sequencer.
// No dependencies.
package wcs_pkg;

    typedef enum logic [2:0] {
        ST_STOPPED = 3'd0,
        ST_FORWARD = 3'd1,
        ST_BACK    = 3'd2,
        ST_PAUSED  = 3'd3,
        ST_ERROR   = 3'd4,
        ST_HOME1   = 3'd5,
        ST_HOME2   = 3'd6
    } cycle_t;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_BLOCKED       = 2'd1,
        ERR_HOME1_TIMEOUT = 2'd2,
        ERR_HOME2_TIMEOUT = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        MOT_STOP    = 2'd0,
        MOT_FORWARD = 2'd1,
        MOT_REVERSE = 2'd2
    } motor_t;

    localparam logic [1:0] REG_HOMING_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_PRESS_HOLDOFF  = 2'd1;
    localparam logic [1:0] REG_HOMING_SPEED   = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET      = 16'd10000;
    localparam logic [9:0]  HOLDOFF_RESET      = 10'd300;
    localparam logic [10:0] HOMING_SPEED_RESET = 11'd400;

    localparam logic [10:0] SPEED_MIN  = 11'd100;
    localparam logic [10:0] SPEED_MAX  = 11'd2000;
    localparam logic [10:0] SPEED_SPAN = 11'd1900;
    localparam logic [11:0] POT_FULL   = 12'd4095;

    typedef struct packed {
        logic button_down;
        logic limit_a_hit;
        logic limit_b_hit;
        logic limit_c_hit;
        logic limit_d_hit;
    } switches_t;

    typedef struct packed {
        logic [15:0] homing_timeout_ticks;
        logic [9:0]  press_holdoff_ticks;
    } seq_cfg_t;

    typedef struct packed {
        cycle_t cycle;
        logic   relay;
        motor_t motor_one;
        motor_t motor_two;
        logic   homed;
        fault_t fault;
    } seq_status_t;

    // pot * 1900 / 4095 + 100; split x = h*4096 + l = h*4095 + (h + l), h + l < 2*4095
    function automatic logic [10:0] map_speed(input logic [11:0] pot);
        logic [22:0] prod;
        logic [10:0] hi;
        logic [12:0] fold;
        logic [10:0] quot;
        prod = 23'(pot) * 23'(SPEED_SPAN);
        hi   = prod[22:12];
        fold = 13'(hi) + 13'(prod[11:0]);
        quot = hi + ((fold >= 13'(POT_FULL)) ? 11'd1 : 11'd0);
        return quot + SPEED_MIN;
    endfunction

    function automatic logic [10:0] clamp_speed(input logic [10:0] speed);
        logic [10:0] res;
        res = speed;
        if (speed < SPEED_MIN)
        begin
            res = SPEED_MIN;
        end
        if (speed > SPEED_MAX)
        begin
            res = SPEED_MAX;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/wcs_cycle_fsm.sv
// Cycle state machine of the weld sequencer: press detection, hold-off,
// homing timer and fault latch. Depends on wcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcs_cycle_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  wcs_pkg::switches_t  sw,
    input  wcs_pkg::seq_cfg_t   cfg,
    output wcs_pkg::seq_status_t status
);
    import wcs_pkg::*;

    cycle_t      cycle_reg,   cycle_next;
    logic        homed_reg,   homed_next;
    logic        latch_reg,   latch_next;
    logic [15:0] timer_reg,   timer_next;
    logic [9:0]  holdoff_reg, holdoff_next;
    logic        relay_reg,   relay_next;
    fault_t      fault_reg,   fault_next;

    logic blocked;

    assign blocked = (sw.limit_a_hit && sw.limit_b_hit) || (sw.limit_c_hit && sw.limit_d_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg   <= ST_STOPPED;
            homed_reg   <= 1'b0;
            latch_reg   <= 1'b0;
            timer_reg   <= '0;
            holdoff_reg <= '0;
            relay_reg   <= 1'b0;
            fault_reg   <= ERR_NONE;
        end
        else if (advance)
        begin
            cycle_reg   <= cycle_next;
            homed_reg   <= homed_next;
            latch_reg   <= latch_next;
            timer_reg   <= timer_next;
            holdoff_reg <= holdoff_next;
            relay_reg   <= relay_next;
            fault_reg   <= fault_next;
        end
    end

    always_comb
    begin
        cycle_next   = cycle_reg;
        homed_next   = homed_reg;
        latch_next   = latch_reg;
        timer_next   = timer_reg;
        holdoff_next = holdoff_reg;
        relay_next   = relay_reg;
        fault_next   = fault_reg;

        // press handling
        if (holdoff_reg != '0)
        begin
            holdoff_next = holdoff_reg - 10'd1;
        end
        else if (sw.button_down && !latch_reg)
        begin
            latch_next   = 1'b1;
            holdoff_next = cfg.press_holdoff_ticks;
            if (blocked)
            begin
                cycle_next = ST_ERROR;
                relay_next = 1'b0;
                fault_next = ERR_BLOCKED;
            end
            else
            begin
                case (cycle_reg)
                    ST_STOPPED:
                    begin
                        if (!homed_reg)
                        begin
                            cycle_next = ST_HOME1;
                            timer_next = '0;
                        end
                        else
                        begin
                            cycle_next = ST_FORWARD;
                            relay_next = 1'b1;
                        end
                    end
                    ST_PAUSED:
                    begin
                        cycle_next = ST_FORWARD;
                        relay_next = 1'b1;
                    end
                    ST_FORWARD, ST_BACK:
                    begin
                        cycle_next = ST_PAUSED;
                        relay_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (!sw.button_down)
        begin
            latch_next = 1'b0;
        end

        // state action
        case (cycle_next)
            ST_HOME1:
            begin
                if (sw.limit_a_hit)
                begin
                    timer_next = '0;
                    cycle_next = ST_HOME2;
                end
                else if (timer_next >= cfg.homing_timeout_ticks)
                begin
                    cycle_next = ST_ERROR;
                    relay_next = 1'b0;
                    fault_next = ERR_HOME1_TIMEOUT;
                end
                else
                begin
                    timer_next = timer_next + 16'd1;
                end
            end
            ST_HOME2:
            begin
                if (sw.limit_c_hit)
                begin
                    timer_next = '0;
                    homed_next = 1'b1;
                    cycle_next = ST_STOPPED;
                end
                else if (timer_next >= cfg.homing_timeout_ticks)
                begin
                    cycle_next = ST_ERROR;
                    relay_next = 1'b0;
                    fault_next = ERR_HOME2_TIMEOUT;
                end
                else
                begin
                    timer_next = timer_next + 16'd1;
                end
            end
            ST_FORWARD:
            begin
                if (sw.limit_b_hit)
                begin
                    relay_next = 1'b0;
                    cycle_next = ST_BACK;
                end
                if (sw.limit_d_hit)
                begin
                    cycle_next = ST_BACK;
                end
            end
            ST_BACK:
            begin
                if (sw.limit_a_hit)
                begin
                    cycle_next = ST_STOPPED;
                end
                if (sw.limit_c_hit)
                begin
                    cycle_next = ST_FORWARD;
                end
            end
            default:
            begin
            end
        endcase

        if (cycle_next == ST_ERROR)
        begin
            relay_next = 1'b0;
        end

        status.cycle     = cycle_next;
        status.relay     = relay_next;
        status.homed     = homed_next;
        status.fault     = fault_next;
        status.motor_one = MOT_STOP;
        status.motor_two = MOT_STOP;
        case (cycle_next)
            ST_FORWARD:
            begin
                status.motor_one = MOT_FORWARD;
                status.motor_two = MOT_FORWARD;
            end
            ST_BACK:
            begin
                status.motor_one = MOT_REVERSE;
                status.motor_two = MOT_REVERSE;
            end
            ST_HOME1:
            begin
                status.motor_one = MOT_REVERSE;
            end
            ST_HOME2:
            begin
                status.motor_two = MOT_REVERSE;
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_CLK(a_error_sticky, (cycle_reg == ST_ERROR) |=> (cycle_reg == ST_ERROR), "error state left before reset")
    `ASSERT_CLK(a_fault_matches_state, (cycle_reg == ST_ERROR) == (fault_reg != ERR_NONE), "fault code disagrees with error state")
    `ASSERT_NEVER(a_relay_off_in_error, (cycle_reg == ST_ERROR) && relay_reg, "relay on in error state")
    `ASSERT_CLK(a_homed_sticky, homed_reg |=> homed_reg, "homed flag dropped")

endmodule

FILE: rtl/core/two_axis_weld_cycle_sequencer.sv
// Top level of the two-axis weld cycle sequencer: request handshakes,
// configuration registers and result register. Depends on wcs_pkg,
// wcs_cycle_fsm and assert_macros.svh.

// One request is one control tick and the block takes one request per clock
// cycle unless the input stalls. A request waits in the input register until
// the result slot is free; then the cycle state machine and the speed mapping
// (one 12 x 11 constant multiply with a fold for the divide by 4095) produce
// its result into the result register, where it is offered until taken.
// The output register lets a new request enter while a result waits;
// the input stalls only when both registers are full and the result is not
// taken. Configuration is written over the APB port at byte addresses 0
// (homing timeout), 4 (press hold-off) and 8 (homing speed); the user must
// write it only while no request is in flight, as the block itself does not
// enforce this. pready is always high.
`include "assert_macros.svh"

module two_axis_weld_cycle_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_down,
    input  logic        limit_a_hit,
    input  logic        limit_b_hit,
    input  logic        limit_c_hit,
    input  logic        limit_d_hit,
    input  logic [11:0] pot_one,
    input  logic [11:0] pot_two,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  cycle_state,
    output logic        relay_on,
    output logic [1:0]  motor_one_cmd,
    output logic [1:0]  motor_two_cmd,
    output logic [10:0] speed_one,
    output logic [10:0] speed_two,
    output logic        homed,
    output logic [1:0]  error_code
);
    import wcs_pkg::*;

    logic [15:0] timeout_reg;
    logic [9:0]  holdoff_cfg_reg;
    logic [10:0] homing_speed_reg;

    logic        in_full_reg,  in_full_next;
    switches_t   sw_reg;
    logic [11:0] pot_one_reg;
    logic [11:0] pot_two_reg;

    logic        out_valid_reg, out_valid_next;
    seq_status_t status_reg;
    logic [10:0] speed_one_reg;
    logic [10:0] speed_two_reg;

    logic        cfg_write;
    logic        advance;
    logic        in_take;
    seq_cfg_t    seq_cfg;
    seq_status_t status;
    logic [10:0] homing_speed_sat;
    logic [10:0] speed_one_next;
    logic [10:0] speed_two_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg      <= TIMEOUT_RESET;
            holdoff_cfg_reg  <= HOLDOFF_RESET;
            homing_speed_reg <= HOMING_SPEED_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_HOMING_TIMEOUT: timeout_reg      <= pwdata[15:0];
                REG_PRESS_HOLDOFF:  holdoff_cfg_reg  <= pwdata[9:0];
                REG_HOMING_SPEED:   homing_speed_reg <= pwdata[10:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_HOMING_TIMEOUT: prdata = 32'(timeout_reg);
            REG_PRESS_HOLDOFF:  prdata = 32'(holdoff_cfg_reg);
            REG_HOMING_SPEED:   prdata = 32'(homing_speed_reg);
            default:            prdata = '0;
        endcase
    end

    assign seq_cfg.homing_timeout_ticks = timeout_reg;
    assign seq_cfg.press_holdoff_ticks  = holdoff_cfg_reg;

    // advance the request in the input register when the result slot is free
    assign advance      = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready     = !in_full_reg || advance;
    assign in_take      = in_valid && in_ready;
    assign in_full_next = in_take || (in_full_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sw_reg.button_down <= button_down;
            sw_reg.limit_a_hit <= limit_a_hit;
            sw_reg.limit_b_hit <= limit_b_hit;
            sw_reg.limit_c_hit <= limit_c_hit;
            sw_reg.limit_d_hit <= limit_d_hit;
            pot_one_reg        <= pot_one;
            pot_two_reg        <= pot_two;
        end
    end

    wcs_cycle_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sw      (sw_reg),
        .cfg     (seq_cfg),
        .status  (status)
    );

    assign homing_speed_sat = clamp_speed(homing_speed_reg);
    assign speed_one_next   = (status.cycle == ST_HOME1) ? homing_speed_sat
                                                         : map_speed(pot_one_reg);
    assign speed_two_next   = (status.cycle == ST_HOME2) ? homing_speed_sat
                                                         : map_speed(pot_two_reg);

    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg    <= status;
            speed_one_reg <= speed_one_next;
            speed_two_reg <= speed_two_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cycle_state   = status_reg.cycle;
    assign relay_on      = status_reg.relay;
    assign motor_one_cmd = status_reg.motor_one;
    assign motor_two_cmd = status_reg.motor_two;
    assign speed_one     = speed_one_reg;
    assign speed_two     = speed_two_reg;
    assign homed         = status_reg.homed;
    assign error_code    = status_reg.fault;

    `ASSERT_CLK(a_full_stall_blocks_input, (in_full_reg && out_valid_reg && !out_ready) |-> !in_ready, "request taken while both stages full and stalled")
    `ASSERT_CLK(a_advance_fills_result, advance |=> out_valid_reg, "advanced request produced no result")
    `ASSERT_CLK(a_speed_in_range, out_valid_reg |-> (speed_one_reg >= SPEED_MIN && speed_one_reg <= SPEED_MAX && speed_two_reg >= SPEED_MIN && speed_two_reg <= SPEED_MAX), "speed outside 100..2000")

endmodule
